/* rtl/motor_pwm_current_limiter_defines.svh */
// assertion macros for the motor pwm current limiter
`ifndef MOTOR_PWM_CURRENT_LIMITER_DEFINES_SVH
`define MOTOR_PWM_CURRENT_LIMITER_DEFINES_SVH
`ifndef SYNTHESIS
`define MPCL_ASSERT_AT(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("mpcl assertion failed");
`define MPCL_ASSERT(label, prop) `MPCL_ASSERT_AT(label, clk_i, rst_ni, prop)
`else
`define MPCL_ASSERT_AT(label, clk, rstn, prop)
`define MPCL_ASSERT(label, prop)
`endif
`endif

/* rtl/mpcl_pkg.sv */
// types, codes and helpers shared by the motor pwm current limiter
`default_nettype none
package mpcl_pkg;

  localparam int DutyW    = 12;
  localparam int CurrentW = 16;
  localparam int BandW    = 15;
  localparam int StepW    = 11;
  localparam int MagW     = 11;
  localparam int ModeW    = 2;
  localparam int AddrW    = 4;
  localparam int DataW    = 32;
  localparam int DutyCap  = 2047;

  typedef logic signed [DutyW-1:0]    duty_t;
  typedef logic signed [CurrentW-1:0] current_t;
  typedef logic        [BandW-1:0]    band_t;
  typedef logic        [StepW-1:0]    step_t;
  typedef logic        [MagW-1:0]     mag_t;
  typedef logic        [ModeW-1:0]    mode_t;
  typedef logic        [1:0]          reg_idx_t;
  typedef logic signed [DutyW+1:0]    duty_wide_t;

  localparam mode_t ModeNormal = 2'd0;
  localparam mode_t ModeHold   = 2'd1;
  localparam mode_t ModeOver   = 2'd2;

  localparam reg_idx_t RegCurrentLimit = 2'd0;
  localparam reg_idx_t RegHystBand     = 2'd1;
  localparam reg_idx_t RegRampStep     = 2'd2;
  localparam reg_idx_t RegBackoffStep  = 2'd3;

  localparam current_t CurrentLimitRst = 16'sd1000;
  localparam band_t    HystBandRst     = 15'd100;
  localparam step_t    RampStepRst     = 11'd40;
  localparam step_t    BackoffStepRst  = 11'd5;

  function automatic duty_wide_t duty_wide(input duty_t v);
    duty_wide = {{2{v[DutyW-1]}}, v};
  endfunction

  function automatic duty_wide_t step_wide(input step_t s);
    step_wide = $signed({3'b000, s});
  endfunction

  // move cur toward tgt by at most step
  function automatic duty_t slew(input duty_t cur, input duty_t tgt, input step_t step);
    duty_wide_t hi;
    duty_wide_t lo;
    duty_wide_t t;
    hi = duty_wide(cur) + step_wide(step);
    lo = duty_wide(cur) - step_wide(step);
    t  = duty_wide(tgt);
    if (t > hi) begin
      slew = hi[DutyW-1:0];
    end else if (t < lo) begin
      slew = lo[DutyW-1:0];
    end else begin
      slew = tgt;
    end
  endfunction

endpackage
`default_nettype wire

/* rtl/mpcl_if.sv */
// request and result channels of the motor pwm current limiter
`default_nettype none
interface mpcl_in_if;
  import mpcl_pkg::*;
  logic     valid;
  logic     ready;
  logic     action;
  duty_t    commanded_duty;
  current_t measured_current;

  modport source (output valid, output action, output commanded_duty,
                  output measured_current, input ready);
  modport sink   (input valid, input action, input commanded_duty,
                  input measured_current, output ready);
endinterface

interface mpcl_out_if;
  import mpcl_pkg::*;
  logic  valid;
  logic  ready;
  mag_t  duty_magnitude;
  logic  clockwise;
  mode_t limit_state;

  modport source (output valid, output duty_magnitude, output clockwise,
                  output limit_state, input ready);
  modport sink   (input valid, input duty_magnitude, input clockwise,
                  input limit_state, output ready);
endinterface
`default_nettype wire

/* rtl/motor_pwm_current_limiter.sv */
// motor pwm current limiter top level
//
//   port    dir  handshake      contents
//   in_i    in   valid/ready    action, commanded_duty, measured_current
//   out_o   out  valid/ready    duty_magnitude, clockwise, limit_state
//   apb     in   psel/penable   current_limit, hysteresis_band, ramp_step, backoff_step
//
// one request per cycle sustained while out_o.ready is high; a request waits in the input register until it moves on
// input register, one pass of compare/add logic, then result register
// limiter and drive state update as a request moves into the result register
// while a result waits the input register takes one more request, then ready drops
// rst_ni clears state, handshake valids and config registers to defaults
`default_nettype none
`include "motor_pwm_current_limiter_defines.svh"
module motor_pwm_current_limiter #(
  parameter int FULL_SCALE = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  mpcl_in_if.sink                       in_i,
  mpcl_out_if.source                    out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mpcl_pkg::AddrW-1:0]    paddr,
  input  logic [mpcl_pkg::DataW-1:0]    pwdata,
  output logic [mpcl_pkg::DataW-1:0]    prdata,
  output logic                          pready
);
  import mpcl_pkg::*;

  localparam int    Lim    = (FULL_SCALE > DutyCap) ? DutyCap : FULL_SCALE;
  localparam duty_t LimPos = duty_t'(Lim);
  localparam duty_t LimNeg = duty_t'(-Lim);

  // config registers
  current_t limit_q;
  band_t    band_q;
  step_t    ramp_q;
  step_t    backoff_q;
  logic     wr_en;
  reg_idx_t wr_idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign wr_idx = paddr[AddrW-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q   <= CurrentLimitRst;
      band_q    <= HystBandRst;
      ramp_q    <= RampStepRst;
      backoff_q <= BackoffStepRst;
    end else if (wr_en) begin
      unique case (wr_idx)
        RegCurrentLimit: limit_q   <= pwdata[CurrentW-1:0];
        RegHystBand:     band_q    <= pwdata[BandW-1:0];
        RegRampStep:     ramp_q    <= pwdata[StepW-1:0];
        RegBackoffStep:  backoff_q <= pwdata[StepW-1:0];
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (wr_idx)
      RegCurrentLimit: prdata = {{(DataW-CurrentW){limit_q[CurrentW-1]}}, limit_q};
      RegHystBand:     prdata = {{(DataW-BandW){1'b0}}, band_q};
      RegRampStep:     prdata = {{(DataW-StepW){1'b0}}, ramp_q};
      RegBackoffStep:  prdata = {{(DataW-StepW){1'b0}}, backoff_q};
    endcase
  end

  // input register
  logic     in_vld_q;
  logic     in_action_q;
  duty_t    in_cmd_q;
  current_t in_cur_q;
  logic     move;

  assign move       = in_vld_q & (~out_o.valid | out_o.ready);
  assign in_i.ready = ~in_vld_q | move;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_action_q <= in_i.action;
      in_cmd_q    <= in_i.commanded_duty;
      in_cur_q    <= in_i.measured_current;
    end
  end

  // limiter and drive state
  duty_t ld_q, ld_d;
  duty_t drive_q, drive_d;
  mode_t mode_q, mode_d;
  duty_t cmd_sat;
  logic signed [CurrentW:0] lim_lo;
  logic signed [CurrentW:0] cur_ext;
  duty_t drive_abs;

  always_comb begin
    cmd_sat = in_cmd_q;
    if (in_cmd_q > LimPos) begin
      cmd_sat = LimPos;
    end else if (in_cmd_q < LimNeg) begin
      cmd_sat = LimNeg;
    end
  end

  assign lim_lo  = $signed({limit_q[CurrentW-1], limit_q}) - $signed({2'b00, band_q});
  assign cur_ext = $signed({in_cur_q[CurrentW-1], in_cur_q});

  always_comb begin
    mode_d = mode_q;
    if (!in_action_q) begin
      priority if (in_cur_q > limit_q) begin
        mode_d = ModeOver;
      end else if (cur_ext < lim_lo) begin
        mode_d = ModeNormal;
      end else begin
        mode_d = (mode_q == ModeOver) ? ModeHold : ModeNormal;
      end
    end
  end

  always_comb begin
    ld_d = ld_q;
    if (!in_action_q) begin
      unique case (mode_d)
        ModeNormal: ld_d = slew(ld_q, cmd_sat, ramp_q);
        ModeOver: begin
          if (cmd_sat > 0) begin
            if (duty_wide(ld_q) > step_wide(backoff_q)) begin
              ld_d = ld_q - $signed({1'b0, backoff_q});
            end
          end else begin
            if (duty_wide(ld_q) < -step_wide(backoff_q)) begin
              ld_d = ld_q + $signed({1'b0, backoff_q});
            end
          end
        end
        default: ld_d = ld_q;
      endcase
    end
  end

  assign drive_d   = in_action_q ? '0 : slew(drive_q, ld_d, ramp_q);
  assign drive_abs = (drive_d < 0) ? -drive_d : drive_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ld_q    <= '0;
      drive_q <= '0;
      mode_q  <= ModeNormal;
    end else if (move) begin
      ld_q    <= ld_d;
      drive_q <= drive_d;
      mode_q  <= mode_d;
    end
  end

  // result register
  logic  out_vld_q;
  mag_t  out_mag_q;
  logic  out_cw_q;
  mode_t out_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (move) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      out_mag_q  <= drive_abs[MagW-1:0];
      out_cw_q   <= (drive_d > 0);
      out_mode_q <= mode_d;
    end
  end

  assign out_o.valid          = out_vld_q;
  assign out_o.duty_magnitude = out_mag_q;
  assign out_o.clockwise      = out_cw_q;
  assign out_o.limit_state    = out_mode_q;

  `MPCL_ASSERT(a_drive_range, (drive_q <= LimPos) && (drive_q >= LimNeg))
  `MPCL_ASSERT(a_limiter_range, (ld_q <= LimPos) && (ld_q >= LimNeg))
  `MPCL_ASSERT(a_idle_clears, (move && in_action_q) |=> ((out_mag_q == '0) && !out_cw_q))
  `MPCL_ASSERT(a_idle_keeps, (move && in_action_q) |=> ($stable(ld_q) && $stable(mode_q)))
  `MPCL_ASSERT(a_no_drop, (in_vld_q && !move) |=> in_vld_q)

endmodule
`default_nettype wire
